### rtl/rssi_energy_detector_core_assert.svh
// Assertion macros for the RSSI energy detector
`ifndef RSSI_ENERGY_DETECTOR_CORE_ASSERT_SVH
`define RSSI_ENERGY_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define RSSIED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RSSIED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RSSIED_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define RSSIED_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/rssied_pkg.sv
package rssied_pkg;

    localparam int MAX_SAMPLES        = 4096;
    localparam int PERIOD_COUNT_WIDTH = 32;

    localparam int CODE_W   = 8;
    localparam int SUM_W    = $clog2(MAX_SAMPLES * 255 + 1);
    localparam int COUNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int MAG_W    = 11;
    localparam int FIELD_W  = 12;
    localparam int TOTAL_W  = 48;
    localparam int PERIOD_W = PERIOD_COUNT_WIDTH;

    localparam int MARGIN_W   = 10;
    localparam int OFFSET_W   = 12;
    localparam int BWIDTH_W   = 10;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // shared divider sizing
    localparam int DIV_W     = TOTAL_W;
    localparam int DVS_A     = (PERIOD_W + 1 > COUNT_W) ? PERIOD_W + 1 : COUNT_W;
    localparam int DVS_W     = (DVS_A > BWIDTH_W) ? DVS_A : BWIDTH_W;
    localparam int STEP_W    = $clog2(DIV_W + 1);
    localparam int EDIV_BITS = SUM_W + 3;

    localparam logic [TOTAL_W-1:0]  TOTAL_FLOOR = TOTAL_W'(1) << (TOTAL_W - 1);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_OFFSET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_WIDTH     = 2'd2;

    localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd16;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd2040;
    localparam logic [BWIDTH_W-1:0] BWIDTH_RST = 10'd80;

    localparam logic [1:0] KIND_QUIET   = 2'd0;
    localparam logic [1:0] KIND_INITIAL = 2'd1;
    localparam logic [1:0] KIND_DETECT  = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] rssi_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                report_kind;
        logic signed [FIELD_W-1:0] energy;
        logic signed [FIELD_W-1:0] background;
        logic [FIELD_W-1:0]        bar_length;
        logic                      empty_period;
    } out_item_t;

    typedef struct packed {
        logic [MARGIN_W-1:0] detect_margin;
        logic [OFFSET_W-1:0] bar_offset;
        logic [BWIDTH_W-1:0] bar_width;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;   // left aligned
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] nbits;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDIV,
        ST_ACC,
        ST_BGDIV,
        ST_BARDIV,
        ST_OUT
    } seq_state_t;

endpackage

### rtl/rssi_energy_detector_core.sv
// RSSI energy detector. Sample items (mode 0) are taken one per cycle while idle
// and summed; a period-end item (mode 1) yields one result: mean energy, running
// background, detection kind and bar length. Period end runs three divisions
// in turn on one shared restoring divider, one quotient bit per cycle
// (23 + 48 + 12 steps), so the next item is taken only once the result has gone
// to the output register, which waits while that register still holds an
// earlier result that the sink has not taken.
// Results sit in an output register, so a tick may start while the previous
// result still waits. bar_width 0 acts as 1; counters saturate.
`include "rssi_energy_detector_core_assert.svh"

module rssi_energy_detector_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [rssied_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rssied_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  rssied_pkg::in_item_t                   s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rssied_pkg::out_item_t                  m_item
);
    import rssied_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    logic      res_valid;
    logic      res_ready;
    out_item_t res;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DETECT_MARGIN: cfg_next.detect_margin = cfg_wdata[MARGIN_W-1:0];
                CFG_BAR_OFFSET:    cfg_next.bar_offset    = cfg_wdata[OFFSET_W-1:0];
                CFG_BAR_WIDTH:     cfg_next.bar_width     = cfg_wdata[BWIDTH_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_item_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_margin <= MARGIN_RST;
            cfg_reg.bar_offset    <= OFFSET_RST;
            cfg_reg.bar_width     <= BWIDTH_RST;
            m_valid_reg           <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    rssied_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    rssied_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    `RSSIED_ASSERT_NXT(a_result_lands, aclk, aresetn, res_valid && res_ready, m_valid)
    `RSSIED_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, res_valid, !s_ready)
    `RSSIED_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_valid && m_item.empty_period, m_item.energy == 0)
    `RSSIED_ASSERT_IMP(a_kind_legal, aclk, aresetn, m_valid, m_item.report_kind <= KIND_DETECT)

endmodule

### rtl/rssied_div.sv
module rssied_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  rssied_pkg::div_req_t req,
    output rssied_pkg::div_rsp_t rsp
);
    import rssied_pkg::*;

    logic              active_reg, active_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        quo_next    = quo_reg;
        if (req.start) begin
            active_next = 1'b1;
            cnt_next    = req.nbits;
            rem_next    = '0;
            dvs_next    = req.divisor;
            quo_next    = req.dividend;
        end else if (active_reg) begin
            if (cnt_reg != '0) begin
                cnt_next = cnt_reg - STEP_W'(1);
                if (!diff[DVS_W]) begin
                    rem_next = diff[DVS_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DVS_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
            end else begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = active_reg && (cnt_reg == '0);
    assign rsp.quotient = quo_reg;

endmodule

### rtl/rssied_seq.sv
module rssied_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rssied_pkg::cfg_t      cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rssied_pkg::in_item_t  s_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output rssied_pkg::out_item_t res,
    output rssied_pkg::div_req_t  div_req,
    input  rssied_pkg::div_rsp_t  div_rsp
);
    import rssied_pkg::*;

    seq_state_t state_reg, state_next;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [PERIOD_W-1:0] periods_reg, periods_next;
    logic                empty_reg, empty_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [FIELD_W-1:0]  bg_reg, bg_next;
    logic [FIELD_W-1:0]  bar_reg, bar_next;

    logic                accept;
    logic [TOTAL_W-1:0]  total_sum;
    logic [TOTAL_W-1:0]  total_sat;
    logic [FIELD_W-1:0]  energy;
    logic [FIELD_W:0]    shifted;
    logic [FIELD_W-1:0]  bar_dividend;
    logic [BWIDTH_W-1:0] bin_width;
    logic [FIELD_W:0]    excess;
    logic [1:0]          kind;

    assign accept = s_valid && s_ready;

    assign total_sum = total_reg + TOTAL_W'(mag_reg);
    assign total_sat = (total_sum > TOTAL_FLOOR) ? TOTAL_FLOOR : total_sum;

    assign energy    = FIELD_W'(0) - FIELD_W'(mag_reg);
    assign shifted   = {energy[FIELD_W-1], energy} + {1'b0, cfg.bar_offset};
    assign bar_dividend = (!shifted[FIELD_W] && (shifted != '0)) ?
                          shifted[FIELD_W-1:0] : '0;
    assign bin_width = (cfg.bar_width == '0) ? BWIDTH_W'(1) : cfg.bar_width;

    assign excess = {energy[FIELD_W-1], energy} - {bg_reg[FIELD_W-1], bg_reg};

    always_comb begin
        if (periods_reg == '0) begin
            kind = KIND_INITIAL;
        end else if ((periods_reg > PERIOD_W'(1)) &&
                     ($signed(excess) > $signed((FIELD_W+1)'(cfg.detect_margin)))) begin
            kind = KIND_DETECT;
        end else begin
            kind = KIND_QUIET;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_item.mode == MODE_TICK)) begin
                    state_next = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (div_rsp.done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = ST_BGDIV;
            end
            ST_BGDIV: begin
                if (div_rsp.done) begin
                    state_next = ST_BARDIV;
                end
            end
            ST_BARDIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready          = 1'b0;
        res_valid        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'({sum_reg, 3'b000}) << (DIV_W - EDIV_BITS);
        div_req.divisor  = DVS_W'(count_reg);
        div_req.nbits    = STEP_W'(EDIV_BITS);
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                div_req.start = s_valid && (s_item.mode == MODE_TICK);
            end
            ST_ACC: begin
                div_req.start    = 1'b1;
                div_req.dividend = total_sat;
                div_req.divisor  = DVS_W'((PERIOD_W+1)'(periods_reg) + (PERIOD_W+1)'(1));
                div_req.nbits    = STEP_W'(DIV_W);
            end
            ST_BGDIV: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = DIV_W'(bar_dividend) << (DIV_W - FIELD_W);
                div_req.divisor  = DVS_W'(bin_width);
                div_req.nbits    = STEP_W'(FIELD_W);
            end
            ST_OUT: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        periods_next = periods_reg;
        empty_next   = empty_reg;
        mag_next     = mag_reg;
        bg_next      = bg_reg;
        bar_next     = bar_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_item.mode == MODE_SAMPLE) begin
                        if (count_reg < COUNT_W'(MAX_SAMPLES)) begin
                            sum_next   = sum_reg + SUM_W'(s_item.rssi_code);
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end else begin
                        empty_next = (count_reg == '0);
                    end
                end
            end
            ST_EDIV: begin
                if (div_rsp.done) begin
                    mag_next = empty_reg ? '0 : div_rsp.quotient[MAG_W-1:0];
                end
            end
            ST_ACC: begin
                total_next = total_sat;
            end
            ST_BGDIV: begin
                if (div_rsp.done) begin
                    bg_next = FIELD_W'(0) - div_rsp.quotient[FIELD_W-1:0];
                end
            end
            ST_BARDIV: begin
                if (div_rsp.done) begin
                    bar_next = div_rsp.quotient[FIELD_W-1:0];
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    sum_next   = '0;
                    count_next = '0;
                    if (periods_reg != PERIOD_MAX) begin
                        periods_next = periods_reg + PERIOD_W'(1);
                    end
                end
            end
            default: begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            periods_reg <= '0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            periods_reg <= periods_next;
        end
        empty_reg <= empty_next;
        mag_reg   <= mag_next;
        bg_reg    <= bg_next;
        bar_reg   <= bar_next;
    end

    assign res.report_kind  = kind;
    assign res.energy       = energy;
    assign res.background   = bg_reg;
    assign res.bar_length   = bar_reg;
    assign res.empty_period = empty_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rssied_pkg::*;

    typedef struct {
        logic       mode;
        logic [7:0] code;
        int         reps;
        bit         fixed;
        out_item_t  want;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;

    // predictor state
    logic [MARGIN_W-1:0] margin_r = MARGIN_RST;
    logic [OFFSET_W-1:0] offset_r = OFFSET_RST;
    logic [BWIDTH_W-1:0] width_r  = BWIDTH_RST;
    longint unsigned     acc_sum    = 0;
    longint unsigned     acc_cnt    = 0;
    longint unsigned     total_mag  = 0;
    longint unsigned     period_cnt = 0;

    out_item_t expected_reports[$];
    out_item_t next_report;
    stim_row_t plan[$];
    int        mismatch_count = 0;
    int        src_idle_pct   = 0;
    int        sink_idle_pct  = 0;

    rssi_energy_detector_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic out_item_t predict_period_end();
        out_item_t       r;
        longint          en;
        longint          bg;
        longint          sh;
        longint          bar;
        longint          w;
        if (acc_cnt == 0) begin
            en = 0;
            r.empty_period = 1'b1;
        end else begin
            en = -longint'((acc_sum * 8) / acc_cnt);
            r.empty_period = 1'b0;
        end
        total_mag = total_mag + longint'(-en);
        if (total_mag > (64'd1 << 47)) total_mag = 64'd1 << 47;
        bg = -longint'(total_mag / (period_cnt + 1));
        r.report_kind = KIND_QUIET;
        if (period_cnt < 1) begin
            r.report_kind = KIND_INITIAL;
        end else if (period_cnt > 1 && (en - bg) > longint'(margin_r)) begin
            r.report_kind = KIND_DETECT;
        end
        w   = (width_r == 0) ? 1 : longint'(width_r);
        sh  = en + longint'(offset_r);
        bar = (sh > 0) ? sh / w : 0;
        r.energy     = en[FIELD_W-1:0];
        r.background = bg[FIELD_W-1:0];
        r.bar_length = bar[FIELD_W-1:0];
        if (period_cnt < PERIOD_MAX) period_cnt++;
        acc_sum = 0;
        acc_cnt = 0;
        return r;
    endfunction

    task automatic feed(input in_item_t it, input bit fixed, input out_item_t want);
        out_item_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.mode == MODE_TICK) begin
            r = predict_period_end();
            expected_reports.push_back(fixed ? want : r);
        end else if (acc_cnt < MAX_SAMPLES) begin
            acc_sum += it.rssi_code;
            acc_cnt++;
        end
    endtask

    task automatic wait_drained(input int settle);
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] margin,
                               input logic [CFG_DATA_W-1:0] offset,
                               input logic [CFG_DATA_W-1:0] width);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_DETECT_MARGIN;
        idx[1] = CFG_BAR_OFFSET;
        idx[2] = CFG_BAR_WIDTH;
        val[0] = margin;
        val[1] = offset;
        val[2] = width;
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        margin_r = margin[MARGIN_W-1:0];
        offset_r = offset[OFFSET_W-1:0];
        width_r  = width[BWIDTH_W-1:0];
    endtask

    function automatic void add_row(input logic mode, input logic [7:0] code, input int reps,
                                    input bit fixed = 1'b0, input logic [1:0] kind = KIND_QUIET,
                                    input int en = 0, input int bg = 0, input int bar = 0,
                                    input bit empty = 1'b0);
        stim_row_t row;
        row.mode = mode;
        row.code = code;
        row.reps = reps;
        row.fixed = fixed;
        row.want.report_kind  = kind;
        row.want.energy       = FIELD_W'(en);
        row.want.background   = FIELD_W'(bg);
        row.want.bar_length   = FIELD_W'(bar);
        row.want.empty_period = empty;
        plan.push_back(row);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    next_report = expected_reports.pop_front();
                    if (m_item.report_kind !== next_report.report_kind)
                        report_mismatch("report_kind", m_item.report_kind,
                                        next_report.report_kind);
                    if (m_item.energy !== next_report.energy)
                        report_mismatch("energy", m_item.energy, next_report.energy);
                    if (m_item.background !== next_report.background)
                        report_mismatch("background", m_item.background,
                                        next_report.background);
                    if (m_item.bar_length !== next_report.bar_length)
                        report_mismatch("bar_length", m_item.bar_length,
                                        next_report.bar_length);
                    if (m_item.empty_period !== next_report.empty_period)
                        report_mismatch("empty_period", m_item.empty_period,
                                        next_report.empty_period);
                end
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        in_item_t it;
        int       sent;
        int       roll;
        int       nsamp;
        int       style;

        // reset defaults: empty first period, full-scale quiet period, zero-level detection, empty detection later on
        add_row(MODE_TICK, 8'h00, 1, 1'b1, KIND_INITIAL, 0, 0, 25, 1'b1);
        add_row(MODE_SAMPLE, 8'hFF, 1);
        add_row(MODE_TICK, 8'h00, 1, 1'b1, KIND_QUIET, -2040, -1020, 0, 1'b0);
        add_row(MODE_SAMPLE, 8'h00, 1);
        add_row(MODE_TICK, 8'h00, 1, 1'b1, KIND_DETECT, 0, -680, 25, 1'b0);
        add_row(MODE_TICK, 8'h00, 1, 1'b1, KIND_DETECT, 0, -510, 25, 1'b1);
        add_row(MODE_SAMPLE, 8'h01, 1);
        add_row(MODE_SAMPLE, 8'h02, 1);
        add_row(MODE_TICK, 8'h00, 1);
        add_row(MODE_SAMPLE, 8'h01, 2);
        add_row(MODE_SAMPLE, 8'h00, 1);
        add_row(MODE_TICK, 8'h00, 1);
        add_row(MODE_SAMPLE, 8'h55, 1);
        add_row(MODE_SAMPLE, 8'hAA, 1);
        add_row(MODE_SAMPLE, 8'h0F, 1);
        add_row(MODE_SAMPLE, 8'hF0, 1);
        add_row(MODE_TICK, 8'hFF, 1);
        add_row(MODE_TICK, 8'hFF, 1);
        add_row(MODE_SAMPLE, 8'hFF, 2);
        add_row(MODE_TICK, 8'h00, 1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 12;
        sink_idle_pct = 78;
        foreach (plan[i]) begin
            for (int k = 0; k < plan[i].reps; k++) begin
                it.mode      = plan[i].mode;
                it.rssi_code = plan[i].code;
                feed(it, plan[i].fixed, plan[i].want);
            end
        end

        for (int seg = 0; seg < 6; seg++) begin
            wait_drained(100);
            case (seg)
                0: load_config(0, 0, 1);
                1: load_config(1023, 4095, 1023);
                2: load_config(CFG_DATA_W'($urandom_range(0, 1023)),
                               CFG_DATA_W'($urandom_range(0, 4095)), 0);
                3: load_config(CFG_DATA_W'($urandom_range(0, 1023)),
                               CFG_DATA_W'($urandom_range(0, 4095)),
                               CFG_DATA_W'($urandom_range(1, 1023)));
                default: load_config(CFG_DATA_W'($urandom_range(0, 300)),
                                     CFG_DATA_W'($urandom_range(0, 4095)),
                                     CFG_DATA_W'($urandom_range(1, 120)));
            endcase
            src_idle_pct  = (seg < 2) ? 12 : (seg < 4) ? 78 : 0;
            sink_idle_pct = (seg < 2) ? 78 : (seg < 4) ? 12 : 0;
            sent = 0;
            while (sent < 175) begin
                roll = $urandom_range(99);
                if (roll < 5) begin
                    it.mode      = 1'($urandom_range(1));
                    it.rssi_code = 8'($urandom_range(255));
                    feed(it, 1'b0, '0);
                    sent++;
                end else begin
                    nsamp = (roll < 15) ? 0 : (roll < 18) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 10);
                    style = $urandom_range(9);
                    for (int k = 0; k < nsamp; k++) begin
                        it.mode      = MODE_SAMPLE;
                        it.rssi_code = 8'((style < 5) ? $urandom_range(128, 255) :
                                          (style < 8) ? $urandom_range(0, 40) :
                                                        $urandom_range(0, 255));
                        feed(it, 1'b0, '0);
                    end
                    it.mode      = MODE_TICK;
                    it.rssi_code = 8'($urandom_range(255));
                    feed(it, 1'b0, '0);
                    sent += nsamp + 1;
                    if ($urandom_range(14) == 0) wait_drained(0);
                end
            end
        end

        wait_drained(100);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
